// ----- rtl/gcpd_pkg.sv -----
// Shared constants and types of the Gray code pixel decoder.
package gcpd_pkg;

   localparam int PIXEL_COUNT_DEF = 524288;
   localparam int CODE_BITS_DEF   = 11;

   localparam int PIX_W      = 19;
   localparam int BITNUM_W   = 4;
   localparam int SAMPLE_W   = 8;
   localparam int COL_W      = 12;
   localparam int RANGE_W    = 25;     // holds a pixel count up to 2**24
   localparam int COLUMN_MAX = 2047;

   localparam logic signed [COL_W-1:0] COL_REJECT = -12'sd1;

   typedef enum logic {
      OP_ACCUMULATE = 1'b0,
      OP_DECODE     = 1'b1
   } op_type;

   // control that travels with an item down the pipeline
   typedef struct packed {
      logic             valid;
      logic             is_decode;
      logic             pass;       // first sample above second sample
      logic             in_range;   // pixel index addresses a store entry
      logic [PIX_W-1:0] pixel_index;
   } stage_ctrl_type;

endpackage

// ----- rtl/gcpd_store.sv -----
// Per-pixel code store: single write port, registered read, clear sweep after reset.
module gcpd_store #(
   parameter int PIXEL_COUNT = gcpd_pkg::PIXEL_COUNT_DEF,
   parameter int CODE_BITS   = gcpd_pkg::CODE_BITS_DEF,
   localparam int ADDR_W     = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [CODE_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [CODE_BITS-1:0] wr_data,
   output logic                 ready
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXEL_COUNT - 1);

   logic [CODE_BITS-1:0] mem [PIXEL_COUNT];
   logic [CODE_BITS-1:0] rd_data_ff;

   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [CODE_BITS-1:0] mem_wdata;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign mem_we    = clearing_ff || wr_en;
   assign mem_waddr = clearing_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clearing_ff ? '0 : wr_data;

   // read returns the word as it was before a write on the same edge
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clearing_ff;

endmodule

// ----- rtl/gcpd_update.sv -----
// Stages A and B: request capture, read-modify-write of the stored word with forwarding.
module gcpd_update #(
   parameter int PIXEL_COUNT = gcpd_pkg::PIXEL_COUNT_DEF,
   parameter int CODE_BITS   = gcpd_pkg::CODE_BITS_DEF,
   localparam int ADDR_W     = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           take,
   input  logic                           req_operation,
   input  logic [gcpd_pkg::PIX_W-1:0]     req_pixel_index,
   input  logic [gcpd_pkg::BITNUM_W-1:0]  req_bit_number,
   input  logic [gcpd_pkg::SAMPLE_W-1:0]  req_first_sample,
   input  logic [gcpd_pkg::SAMPLE_W-1:0]  req_second_sample,
   output logic [ADDR_W-1:0]              rd_addr,
   input  logic [CODE_BITS-1:0]           rd_data,
   output logic                           wr_en,
   output logic [ADDR_W-1:0]              wr_addr,
   output logic [CODE_BITS-1:0]           wr_data,
   output gcpd_pkg::stage_ctrl_type       b_ctrl,
   output logic [CODE_BITS-1:0]           b_code
);

   gcpd_pkg::stage_ctrl_type a_ctrl_ff, a_ctrl_in;
   logic [CODE_BITS-1:0]     a_mask_ff, a_mask_in;
   logic [ADDR_W-1:0]        a_addr_ff;

   gcpd_pkg::stage_ctrl_type b_ctrl_ff;
   logic [CODE_BITS-1:0]     b_code_ff;
   logic [CODE_BITS-1:0]     b_word_ff;
   logic [ADDR_W-1:0]        b_addr_ff;
   logic                     b_wrote_ff;

   logic                 fwd_hit;
   logic [CODE_BITS-1:0] old_word;
   logic [CODE_BITS-1:0] new_word;

   assign rd_addr = ADDR_W'(req_pixel_index);

   // bit numbers past the word give an empty mask
   always_comb begin
      a_ctrl_in.valid       = take;
      a_ctrl_in.is_decode   = (req_operation == gcpd_pkg::OP_DECODE);
      a_ctrl_in.pass        = (req_first_sample > req_second_sample);
      a_ctrl_in.in_range    = (gcpd_pkg::RANGE_W'(req_pixel_index)
                               < gcpd_pkg::RANGE_W'(PIXEL_COUNT));
      a_ctrl_in.pixel_index = req_pixel_index;
      a_mask_in             = CODE_BITS'(1) << req_bit_number;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff <= '0;
      end else if (advance) begin
         a_ctrl_ff <= a_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_mask_ff <= a_mask_in;
         a_addr_ff <= rd_addr;
      end
   end

   // the item now in stage B wrote on the edge this item read: take its word
   assign fwd_hit  = b_wrote_ff && (b_addr_ff == a_addr_ff);
   assign old_word = fwd_hit ? b_word_ff : rd_data;

   always_comb begin
      if (a_ctrl_ff.is_decode) begin
         new_word = '0;
      end else if (a_ctrl_ff.pass) begin
         new_word = old_word | a_mask_ff;
      end else begin
         new_word = old_word;
      end
   end

   assign wr_en   = advance && a_ctrl_ff.valid && a_ctrl_ff.in_range;
   assign wr_addr = a_addr_ff;
   assign wr_data = new_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctrl_ff  <= '0;
         b_wrote_ff <= 1'b0;
      end else if (advance) begin
         b_ctrl_ff  <= a_ctrl_ff;
         b_wrote_ff <= a_ctrl_ff.valid && a_ctrl_ff.in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_code_ff <= old_word;
         b_word_ff <= new_word;
         b_addr_ff <= a_addr_ff;
      end
   end

   assign b_ctrl = b_ctrl_ff;
   assign b_code = b_code_ff;

endmodule

// ----- rtl/gcpd_decode.sv -----
// Stage C: Gray to binary, mask and saturation, result register.
module gcpd_decode #(
   parameter int CODE_BITS = gcpd_pkg::CODE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  gcpd_pkg::stage_ctrl_type               b_ctrl,
   input  logic [CODE_BITS-1:0]                   b_code,
   output logic                                   rsp_valid,
   output logic signed [gcpd_pkg::COL_W-1:0]      rsp_column_code,
   output logic [gcpd_pkg::PIX_W-1:0]             rsp_out_pixel_index
);

   localparam int EXT_W = (CODE_BITS > gcpd_pkg::COL_W - 1) ? CODE_BITS
                                                            : gcpd_pkg::COL_W - 1;

   logic [CODE_BITS-1:0] bin;
   logic [EXT_W-1:0]     bin_ext;
   logic signed [gcpd_pkg::COL_W-1:0] column_in;

   logic                              rsp_valid_ff;
   logic signed [gcpd_pkg::COL_W-1:0] rsp_column_code_ff;
   logic [gcpd_pkg::PIX_W-1:0]        rsp_out_pixel_index_ff;

   // binary bit i is the parity of Gray bits i and above
   always_comb begin
      for (int i = 0; i < CODE_BITS; i++) begin
         bin[i] = ^(b_code >> i);
      end
   end

   assign bin_ext = EXT_W'(bin);

   always_comb begin
      if (!(b_ctrl.in_range && b_ctrl.pass)) begin
         column_in = gcpd_pkg::COL_REJECT;
      end else if (bin_ext > EXT_W'(gcpd_pkg::COLUMN_MAX)) begin
         column_in = gcpd_pkg::COL_W'(gcpd_pkg::COLUMN_MAX);
      end else begin
         column_in = gcpd_pkg::COL_W'(bin_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= b_ctrl.valid && b_ctrl.is_decode;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_column_code_ff     <= column_in;
         rsp_out_pixel_index_ff <= b_ctrl.pixel_index;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_column_code     = rsp_column_code_ff;
   assign rsp_out_pixel_index = rsp_out_pixel_index_ff;

endmodule

// ----- rtl/gray_code_pixel_decoder_core.sv -----
// A decode result reaches rsp_ through the stage A, B and C registers.
// Throughput: one request transfer per cycle unless stalled, accumulate or decode
// mixed freely. Pipeline: A capture + store read, B modify + write-back, C Gray
// decode + result. Reset: synchronous; afterwards the store is swept to zero,
// all PIXEL_COUNT entries (524288 by default) one per cycle, with req_ready low.
module gray_code_pixel_decoder_core #(
   parameter int PIXEL_COUNT = gcpd_pkg::PIXEL_COUNT_DEF,
   parameter int CODE_BITS   = gcpd_pkg::CODE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [gcpd_pkg::PIX_W-1:0]          req_pixel_index,
   input  logic [gcpd_pkg::BITNUM_W-1:0]       req_bit_number,
   input  logic [gcpd_pkg::SAMPLE_W-1:0]       req_first_sample,
   input  logic [gcpd_pkg::SAMPLE_W-1:0]       req_second_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [gcpd_pkg::COL_W-1:0]   rsp_column_code,
   output logic [gcpd_pkg::PIX_W-1:0]          rsp_out_pixel_index
);

   localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   logic advance;      // whole pipeline steps together
   logic take;         // request transfer this cycle
   logic store_ready;

   logic [ADDR_W-1:0]    rd_addr;
   logic [CODE_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [CODE_BITS-1:0] wr_data;

   gcpd_pkg::stage_ctrl_type b_ctrl;
   logic [CODE_BITS-1:0]     b_code;

   // the result register frees up when empty or when its transfer completes,
   // so a new request enters while the previous result is being taken
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance && store_ready;
   assign take      = req_valid && req_ready;

   gcpd_store #(
      .PIXEL_COUNT (PIXEL_COUNT),
      .CODE_BITS   (CODE_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (take),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .ready   (store_ready)
   );

   // read-modify-write; back-to-back hits on one pixel forward from stage B
   gcpd_update #(
      .PIXEL_COUNT (PIXEL_COUNT),
      .CODE_BITS   (CODE_BITS)
   ) u_update (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .take              (take),
      .req_operation     (req_operation),
      .req_pixel_index   (req_pixel_index),
      .req_bit_number    (req_bit_number),
      .req_first_sample  (req_first_sample),
      .req_second_sample (req_second_sample),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .b_ctrl            (b_ctrl),
      .b_code            (b_code)
   );

   // accumulates leave stage C as bubbles; only decodes raise rsp_valid
   gcpd_decode #(
      .CODE_BITS (CODE_BITS)
   ) u_decode (
      .clock               (clock),
      .reset               (reset),
      .advance             (advance),
      .b_ctrl              (b_ctrl),
      .b_code              (b_code),
      .rsp_valid           (rsp_valid),
      .rsp_column_code     (rsp_column_code),
      .rsp_out_pixel_index (rsp_out_pixel_index)
   );

endmodule

// ----- bench/decoder_checker.sv -----
// Checker for the Gray code pixel decoder: predicts each decode result and compares it.
module decoder_checker #(
   parameter int PIXEL_COUNT = gcpd_pkg::PIXEL_COUNT_DEF,
   parameter int CODE_BITS   = gcpd_pkg::CODE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_operation,
   input  logic [gcpd_pkg::PIX_W-1:0]        req_pixel_index,
   input  logic [gcpd_pkg::BITNUM_W-1:0]     req_bit_number,
   input  logic [gcpd_pkg::SAMPLE_W-1:0]     req_first_sample,
   input  logic [gcpd_pkg::SAMPLE_W-1:0]     req_second_sample,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [gcpd_pkg::COL_W-1:0] rsp_column_code,
   input  logic [gcpd_pkg::PIX_W-1:0]        rsp_out_pixel_index,
   output int                                mismatch_count,
   output int                                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [15:0] CODE_MASK = 16'((32'd1 << CODE_BITS) - 1);

   typedef struct {
      logic signed [gcpd_pkg::COL_W-1:0] column_code;
      logic [gcpd_pkg::PIX_W-1:0]        pixel_index;
   } column_result_type;

   logic [15:0]       gray_words [int unsigned];   // absent entry reads as zero
   column_result_type expected_columns [$];
   int                fail_total = 0;
   int                waiting    = 0;

   assign mismatch_count = fail_total;
   assign pending_count  = waiting;

   function automatic logic [15:0] ungray(input logic [15:0] g);
      logic [15:0] b;
      int          i;
      b[15] = g[15];
      for (i = 14; i >= 0; i--) b[i] = b[i+1] ^ g[i];
      return b;
   endfunction

   task automatic apply_pixel_sample(input gcpd_pkg::op_type op,
                                     input logic [gcpd_pkg::PIX_W-1:0] pix,
                                     input logic [gcpd_pkg::BITNUM_W-1:0] bitn,
                                     input logic [gcpd_pkg::SAMPLE_W-1:0] a,
                                     input logic [gcpd_pkg::SAMPLE_W-1:0] b);
      logic [15:0]       word;
      logic [15:0]       binary;
      column_result_type res;
      bit                in_range;
      in_range = longint'(pix) < longint'(PIXEL_COUNT);
      word     = gray_words.exists(pix) ? gray_words[pix] : 16'h0;
      if (op == gcpd_pkg::OP_ACCUMULATE) begin
         if (in_range && int'(bitn) < CODE_BITS && a > b)
            gray_words[pix] = (word | (16'h1 << bitn)) & CODE_MASK;
      end else begin
         res.column_code = gcpd_pkg::COL_REJECT;
         res.pixel_index = pix;
         if (in_range) begin
            if (a > b) begin
               binary = ungray(word & CODE_MASK);
               if (binary > gcpd_pkg::COLUMN_MAX)
                  res.column_code = gcpd_pkg::COL_W'(gcpd_pkg::COLUMN_MAX);
               else res.column_code = binary[gcpd_pkg::COL_W-1:0];
            end
            gray_words[pix] = 16'h0;
         end
         expected_columns = {expected_columns, res};
      end
   endtask

   always @(posedge clock) begin
      column_result_type want;
      if (reset) begin
         gray_words.delete();
         expected_columns.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_columns.size() == 0) begin
               $display("%0t: result with none outstanding: column %0d pixel %0d",
                        $time, rsp_column_code, rsp_out_pixel_index);
               fail_total++;
            end else begin
               want = expected_columns.pop_front();
               if (rsp_column_code !== want.column_code) begin
                  $display("%0t: column_code expected %0d, actual %0d (pixel %0d)",
                           $time, want.column_code, rsp_column_code, want.pixel_index);
                  fail_total++;
               end
               if (rsp_out_pixel_index !== want.pixel_index) begin
                  $display("%0t: out_pixel_index expected %0d, actual %0d",
                           $time, want.pixel_index, rsp_out_pixel_index);
                  fail_total++;
               end
            end
         end
         if (req_valid && req_ready)
            apply_pixel_sample(gcpd_pkg::op_type'(req_operation), req_pixel_index,
                               req_bit_number, req_first_sample, req_second_sample);
      end
      waiting = expected_columns.size();
   end

endmodule

// ----- bench/testbench.sv -----
// Top of the Gray code pixel decoder testbench: clock, reset, stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [gcpd_pkg::PIX_W-1:0] PIX_LAST     = '1;
   localparam int                         RANDOM_ITEMS = 1100;
   localparam int                         HOLD_CYCLES  = 300;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic                              req_operation;
   logic [gcpd_pkg::PIX_W-1:0]        req_pixel_index;
   logic [gcpd_pkg::BITNUM_W-1:0]     req_bit_number;
   logic [gcpd_pkg::SAMPLE_W-1:0]     req_first_sample;
   logic [gcpd_pkg::SAMPLE_W-1:0]     req_second_sample;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic signed [gcpd_pkg::COL_W-1:0] rsp_column_code;
   logic [gcpd_pkg::PIX_W-1:0]        rsp_out_pixel_index;

   int mismatch_count;
   int pending_count;
   int hold_off_asks = 0;   // bumped by the sender, served by the receiver
   int burst_left    = 0;
   int items_sent    = 0;

   logic [gcpd_pkg::PIX_W-1:0] pixel_pool [8];

   gray_code_pixel_decoder_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_pixel_index     (req_pixel_index),
      .req_bit_number      (req_bit_number),
      .req_first_sample    (req_first_sample),
      .req_second_sample   (req_second_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_column_code     (rsp_column_code),
      .rsp_out_pixel_index (rsp_out_pixel_index)
   );

   decoder_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_pixel_index     (req_pixel_index),
      .req_bit_number      (req_bit_number),
      .req_first_sample    (req_first_sample),
      .req_second_sample   (req_second_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_column_code     (rsp_column_code),
      .rsp_out_pixel_index (rsp_out_pixel_index),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop, placed after the end of the post-reset store sweep.
   initial begin
      #20_000_000;
      $display("testbench failed");
      $finish;
   end

   // Receiver: one of four random stall styles, redrawn on a phase count; a hold-off
   // request from the sender drops ready so the pipe backs up into req_ready.
   initial begin
      int served;
      int style;
      int phase;
      served = 0;
      style  = 0;
      phase  = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (served != hold_off_asks) begin
            served = hold_off_asks;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (phase % 64 == 0) style = $urandom_range(0, 3);
         phase++;
         case (style)
            0:       rsp_ready <= 1'b1;                          // no stalls
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= (phase % 4 == 0);              // one in four
            default: rsp_ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // One request transfer; valid is left high for a following item.
   task automatic offer(input gcpd_pkg::op_type op,
                        input logic [gcpd_pkg::PIX_W-1:0] pix,
                        input logic [gcpd_pkg::BITNUM_W-1:0] bitn,
                        input logic [gcpd_pkg::SAMPLE_W-1:0] a,
                        input logic [gcpd_pkg::SAMPLE_W-1:0] b);
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_pixel_index   <= pix;
      req_bit_number    <= bitn;
      req_first_sample  <= a;
      req_second_sample <= b;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
      items_sent++;
   endtask

   // Random gaps between bursts; long bursts give stretches with no idling.
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                 : $urandom_range(0, 30);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // pass: first sample strictly above the second
   task automatic pick_samples(input bit pass, output logic [gcpd_pkg::SAMPLE_W-1:0] a,
                               output logic [gcpd_pkg::SAMPLE_W-1:0] b);
      if (pass) begin
         a = gcpd_pkg::SAMPLE_W'($urandom_range(1, 255));
         b = gcpd_pkg::SAMPLE_W'($urandom_range(0, a - 1));
      end else begin
         a = gcpd_pkg::SAMPLE_W'($urandom_range(0, 255));
         b = ($urandom_range(0, 2) == 0) ? a
                                         : gcpd_pkg::SAMPLE_W'($urandom_range(a, 255));
      end
   endtask

   initial begin
      logic [gcpd_pkg::PIX_W-1:0]    pix;
      logic [gcpd_pkg::BITNUM_W-1:0] bitn;
      logic [gcpd_pkg::SAMPLE_W-1:0] a;
      logic [gcpd_pkg::SAMPLE_W-1:0] b;
      int                            n;
      int                            k;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = gcpd_pkg::OP_ACCUMULATE;
      req_pixel_index   = '0;
      req_bit_number    = '0;
      req_first_sample  = '0;
      req_second_sample = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: bits at and past the word edge, repeated bit, equal and
      // reversed samples, mask rejection, clearing by decode, last pixel.
      offer(gcpd_pkg::OP_ACCUMULATE, '0, 4'd0,  8'd255, 8'd0);
      offer(gcpd_pkg::OP_ACCUMULATE, '0, 4'd10, 8'd255, 8'd0);
      offer(gcpd_pkg::OP_ACCUMULATE, '0, 4'd11, 8'd255, 8'd0);   // beyond the word
      offer(gcpd_pkg::OP_ACCUMULATE, '0, 4'd15, 8'd255, 8'd0);
      offer(gcpd_pkg::OP_ACCUMULATE, '0, 4'd0,  8'd200, 8'd100); // same bit again
      offer(gcpd_pkg::OP_ACCUMULATE, '0, 4'd1,  8'd128, 8'd128); // equal: no set
      offer(gcpd_pkg::OP_ACCUMULATE, '0, 4'd2,  8'd0,   8'd255);
      offer(gcpd_pkg::OP_DECODE,     '0, 4'd0,  8'd255, 8'd0);
      offer(gcpd_pkg::OP_DECODE,     '0, 4'd15, 8'd1,   8'd0);   // entry now cleared
      offer(gcpd_pkg::OP_ACCUMULATE, PIX_LAST, 4'd5, 8'd255, 8'd254);
      offer(gcpd_pkg::OP_DECODE,     PIX_LAST, 4'd0, 8'd77,  8'd77); // equal white/black
      offer(gcpd_pkg::OP_DECODE,     PIX_LAST, 4'd0, 8'd255, 8'd0);
      offer(gcpd_pkg::OP_DECODE,     PIX_LAST, 4'd0, 8'd0,   8'd255);
      // back-to-back writes to one pixel exercise the read-modify-write bypass
      for (k = 0; k < gcpd_pkg::CODE_BITS_DEF; k++)
         offer(gcpd_pkg::OP_ACCUMULATE, 19'h2AAAA, gcpd_pkg::BITNUM_W'(k), 8'd255, 8'd0);
      offer(gcpd_pkg::OP_DECODE, 19'h2AAAA, 4'd0, 8'd255, 8'd0);

      // sender pause until every result is back
      drain();

      pixel_pool[0] = '0;
      pixel_pool[1] = PIX_LAST;
      pixel_pool[2] = gcpd_pkg::PIX_W'($urandom);
      pixel_pool[3] = pixel_pool[2] + 1'b1;
      for (k = 4; k < 8; k++) pixel_pool[3'(k)] = gcpd_pkg::PIX_W'($urandom);

      // long receiver hold-off while decodes keep coming
      hold_off_asks++;
      for (k = 0; k < 20; k++) begin
         pick_samples(1'b1, a, b);
         offer(gcpd_pkg::OP_DECODE, pixel_pool[3'(k % 8)],
               gcpd_pkg::BITNUM_W'($urandom), a, b);
      end
      drain();

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) begin
            // well-formed scan: bit planes of one pixel, then its decode
            pix = pixel_pool[3'($urandom_range(0, 7))];
            n   = $urandom_range(1, 12);
            for (k = 0; k < n; k++) begin
               bitn = ($urandom_range(0, 9) == 0)
                      ? gcpd_pkg::BITNUM_W'($urandom_range(11, 15))
                      : gcpd_pkg::BITNUM_W'($urandom_range(0, 10));
               pick_samples(1'($urandom_range(0, 1)), a, b);
               offer(gcpd_pkg::OP_ACCUMULATE, pix, bitn, a, b);
               pace();
            end
            pick_samples($urandom_range(0, 6) != 0, a, b);
            offer(gcpd_pkg::OP_DECODE, pix, gcpd_pkg::BITNUM_W'($urandom), a, b);
            pace();
         end else begin
            // noise: anything the fields allow
            pix = ($urandom_range(0, 1) == 0) ? gcpd_pkg::PIX_W'($urandom)
                                             : pixel_pool[3'($urandom_range(0, 7))];
            pick_samples(1'($urandom_range(0, 1)), a, b);
            offer(gcpd_pkg::op_type'($urandom_range(0, 1)), pix,
                  gcpd_pkg::BITNUM_W'($urandom), a, b);
            pace();
         end
      end

      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
